FILE: rtl/tksel_pkg.sv
`default_nettype none
package tksel_pkg;

	localparam int K_MAX      = 16;
	localparam int SCORE_BITS = 16;
	localparam int INDEX_BITS = 16;

	// keep_count register width is fixed at five bits
	localparam int KEEP_W     = 5;
	localparam int CNT_W      = ($clog2(K_MAX + 1) > KEEP_W) ? $clog2(K_MAX + 1) : KEEP_W;
	localparam int CFG_DATA_W = (SCORE_BITS > KEEP_W) ? SCORE_BITS : KEEP_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE  = CFG_IDX_W'(1);

	typedef struct packed {
		logic                  valid;
		logic [SCORE_BITS-1:0] score;
		logic [INDEX_BITS-1:0] index;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                  step;
		logic                  insert;
		logic                  drain;
		logic [SCORE_BITS-1:0] score;
		logic [INDEX_BITS-1:0] index;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/tksel_cell.sv
`default_nettype none
module tksel_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  tksel_pkg::cell_ctrl_t ctrl,
	input  wire                  in_bound,
	input  tksel_pkg::entry_t    prev_entry,
	input  wire                  prev_take,
	input  tksel_pkg::entry_t    next_entry,
	output tksel_pkg::entry_t    entry,
	output logic                 take
);
	import tksel_pkg::*;

	logic                  valid_q;
	logic [SCORE_BITS-1:0] score_q;
	logic [INDEX_BITS-1:0] index_q;
	entry_t                cur;
	entry_t                nxt;

	// entries beyond the active limit read as empty
	always_comb begin
		cur.valid = valid_q & in_bound;
		cur.score = score_q;
		cur.index = index_q;
	end

	// this cell or one to its left is where the new score belongs
	assign take  = ctrl.insert & (~cur.valid | (ctrl.score > cur.score));
	assign entry = cur;

	always_comb begin
		if (ctrl.drain) begin
			nxt = next_entry;
		end else if (prev_take) begin
			nxt = prev_entry;
		end else if (take) begin
			nxt.valid = 1'b1;
			nxt.score = ctrl.score;
			nxt.index = ctrl.index;
		end else begin
			nxt = cur;
		end
	end

	// hold validity between requests; a request or a drain drops entries beyond the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step || ctrl.drain) begin
			valid_q <= nxt.valid & in_bound;
		end
	end

	always_ff @(posedge clk) begin
		score_q <= nxt.score;
		index_q <= nxt.index;
	end

endmodule
`default_nettype wire

FILE: rtl/thresholded_top_k_selector_unit.sv
// A request without end_of_vector leaves the block idle; a new one may follow at once.
// A request with end_of_vector sets busy until the kept entries have drained (one result if none);
// results leave cell 0 one per cycle, the first registered at the edge after the accepting edge.
// Throughput is one request per cycle while the block is not busy; a drain holds off new requests.
// The receiver cannot stall; each result is shown for one cycle with result_strobe.
// Asynchronous active-low reset empties the chain, keep_count to 1 and min_score to 0.
`default_nettype none
module thresholded_top_k_selector_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [tksel_pkg::SCORE_BITS-1:0]    score,
	input  wire  [tksel_pkg::INDEX_BITS-1:0]    item_index,
	input  wire                                 end_of_vector,
	input  wire                                 cfg_write,
	input  wire  [tksel_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [tksel_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                result_strobe,
	output logic [tksel_pkg::SCORE_BITS-1:0]    best_score,
	output logic [tksel_pkg::INDEX_BITS-1:0]    best_index,
	output logic                                entry_valid,
	output logic                                last_entry
);
	import tksel_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t                state_q;
	logic [KEEP_W-1:0]     keep_count_q;
	logic [SCORE_BITS-1:0] min_score_q;
	logic [CNT_W-1:0]      limit;
	logic                  accept;
	cell_ctrl_t            ctrl;

	// chain[K_MAX] is a constant empty slot feeding the tail during a drain
	entry_t                chain [0:K_MAX];
	logic                  takes [0:K_MAX];

	// Configuration registers: the user must write them only while idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(1);
			min_score_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEEP_COUNT: keep_count_q <= cfg_data[KEEP_W-1:0];
				REG_MIN_SCORE:  min_score_q  <= cfg_data[SCORE_BITS-1:0];
				default:        ;
			endcase
		end
	end

	// Clamp keep_count: zero behaves as one, anything above the chain length saturates.
	always_comb begin
		if (keep_count_q == '0) begin
			limit = CNT_W'(1);
		end else if (CNT_W'(keep_count_q) > CNT_W'(K_MAX)) begin
			limit = CNT_W'(K_MAX);
		end else begin
			limit = CNT_W'(keep_count_q);
		end
	end

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start & ~busy;

	// Drop scores below the threshold; a dropped request may still close the vector.
	// Every accepted request, dropped or not, trims the chain to the current limit.
	always_comb begin
		ctrl.step   = accept;
		ctrl.insert = accept & (score >= min_score_q);
		ctrl.drain  = busy;
		ctrl.score  = score;
		ctrl.index  = item_index;
	end

	assign takes[0]       = 1'b0;
	assign chain[K_MAX]   = '0;

	// Cell 0 holds the best entry; a left neighbour of cell 0 would be empty and never take.
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		entry_t left_entry;
		logic   left_take;

		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_take  = takes[0];
		end else begin : g_body
			assign left_entry = chain[i-1];
			assign left_take  = takes[i];
		end

		tksel_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.in_bound   (CNT_W'(i) < limit),
			.prev_entry (left_entry),
			.prev_take  (left_take),
			.next_entry (chain[i+1]),
			.entry      (chain[i]),
			.take       (takes[i+1])
		);
	end

	// Control and result registers. During a drain, emit cell 0 each cycle while the
	// chain shifts towards it; stop once the next cell is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			result_strobe <= 1'b0;
			best_score    <= '0;
			best_index    <= '0;
			entry_valid   <= 1'b0;
			last_entry    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					result_strobe <= 1'b0;
					if (accept && end_of_vector) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					result_strobe <= 1'b1;
					entry_valid   <= chain[0].valid;
					last_entry    <= ~chain[0].valid | ~chain[1].valid;
					// an empty run reports zero payload
					best_score    <= chain[0].valid ? chain[0].score : '0;
					best_index    <= chain[0].valid ? chain[0].index : '0;
					if (!chain[0].valid || !chain[1].valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q       <= ST_IDLE;
					result_strobe <= 1'b0;
				end
			endcase
		end
	end

	// An invalid result always closes the run.
	a_invalid_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !entry_valid |-> last_entry)
		else $error("invalid result not marked last");

	// A drain only starts from an accepted request that closes the vector.
	a_drain_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && end_of_vector))
		else $error("drain started without end of vector");

	// Results appear only out of a drain.
	a_strobe_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result outside a drain");

	// Results of one run come out in non-increasing score order.
	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && $past(result_strobe) && entry_valid |-> best_score <= $past(best_score))
		else $error("results out of order");

	// The last result frees the block.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_entry |-> !busy)
		else $error("busy after last result");

endmodule
`default_nettype wire

FILE: verif/thresholded_top_k_selector_unit_test.sv
`default_nettype none
module thresholded_top_k_selector_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tksel_pkg::*;

	// A run of about 600 requests needs far less than this bound; allow a wide margin.
	localparam int CYCLE_LIMIT   = 400000;
	// Quiet cycles after the last due result before touching a register or ending.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS  = 500;
	localparam int PRINT_LIMIT   = 40;

	// Indexes that decode to no register: writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct {
		logic [SCORE_BITS-1:0] score;
		logic [INDEX_BITS-1:0] index;
		logic                  eov;
	} score_req_t;

	typedef struct {
		logic [SCORE_BITS-1:0] score;
		logic [INDEX_BITS-1:0] index;
		logic                  valid;
		logic                  last;
	} ranked_entry_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  start         = 1'b0;
	logic [SCORE_BITS-1:0] score         = '0;
	logic [INDEX_BITS-1:0] item_index    = '0;
	logic                  end_of_vector = 1'b0;
	logic                  cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	wire                  busy;
	wire                  result_strobe;
	wire [SCORE_BITS-1:0] best_score;
	wire [INDEX_BITS-1:0] best_index;
	wire                  entry_valid;
	wire                  last_entry;

	thresholded_top_k_selector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.score         (score),
		.item_index    (item_index),
		.end_of_vector (end_of_vector),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.best_score    (best_score),
		.best_index    (best_index),
		.entry_valid   (entry_valid),
		.last_entry    (last_entry)
	);

	// Requests waiting to be driven, and ranked entries the block still owes us.
	score_req_t    score_backlog[$];
	ranked_entry_t ranking_due[$];
	ranked_entry_t due_entry;

	// Our own copy of the registers and of the sorted store.
	logic [KEEP_W-1:0]     keep_cfg  = KEEP_W'(1);
	logic [SCORE_BITS-1:0] floor_cfg = '0;
	logic [SCORE_BITS-1:0] held_scores [K_MAX];
	logic [INDEX_BITS-1:0] held_indices[K_MAX];
	int                    held_total = 0;

	int gap_max         = 0;
	int gap_left        = 0;
	int requests_taken  = 0;
	int results_seen    = 0;
	int settings_used   = 0;
	int mismatch_count  = 0;
	int cycle_count     = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] result %0d: %s", $realtime, results_seen, what);
		mismatch_count++;
	endtask

	// Insert one accepted request into the store and, on end of vector,
	// queue the ranked entries it releases.
	function automatic void rank_score(input logic [SCORE_BITS-1:0] s,
			input logic [INDEX_BITS-1:0] idx, input logic eov);
		int            limit;
		int            pos;
		int            tail;
		int            i;
		ranked_entry_t r;

		// zero keeps one, anything above the store depth saturates
		if (keep_cfg == 0)
			limit = 1;
		else if (int'(keep_cfg) > K_MAX)
			limit = K_MAX;
		else
			limit = int'(keep_cfg);

		// a lowered keep_count trims the store, keeping the best entries
		if (held_total > limit)
			held_total = limit;

		if (s >= floor_cfg) begin
			pos = 0;
			// equal scores stay behind the ones already held
			while (pos < held_total && held_scores[pos] >= s)
				pos++;
			if (pos < limit) begin
				tail = (held_total < limit) ? held_total : limit - 1;
				for (i = tail; i > pos; i--) begin
					held_scores[i]  = held_scores[i-1];
					held_indices[i] = held_indices[i-1];
				end
				held_scores[pos]  = s;
				held_indices[pos] = idx;
				if (held_total < limit)
					held_total++;
			end
		end

		if (eov) begin
			if (held_total == 0) begin
				// nothing passed the threshold: one invalid marker
				r.score = '0;
				r.index = '0;
				r.valid = 1'b0;
				r.last  = 1'b1;
				ranking_due = {ranking_due, r};
			end else begin
				for (i = 0; i < held_total; i++) begin
					r.score = held_scores[i];
					r.index = held_indices[i];
					r.valid = 1'b1;
					r.last  = (i == held_total - 1);
					ranking_due = {ranking_due, r};
				end
			end
			held_total = 0;
		end
	endfunction

	// Driver: present requests from the backlog, hold while busy,
	// then idle for the gap drawn with each request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			score         <= '0;
			item_index    <= '0;
			end_of_vector <= 1'b0;
			gap_left      <= 0;
		end else if (!(start && busy)) begin
			if (start) begin
				rank_score(score, item_index, end_of_vector);
				requests_taken <= requests_taken + 1;
			end
			if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (score_backlog.size() != 0) begin
				score         <= score_backlog[0].score;
				item_index    <= score_backlog[0].index;
				end_of_vector <= score_backlog[0].eov;
				start         <= 1'b1;
				gap_left      <= $urandom_range(0, gap_max);
				void'(score_backlog.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe must match the oldest due entry, field by field.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (ranking_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result score %h index %h",
					best_score, best_index));
			end else begin
				due_entry = ranking_due.pop_front();
				if (best_score !== due_entry.score)
					report_mismatch($sformatf("best_score %h, want %h",
						best_score, due_entry.score));
				if (best_index !== due_entry.index)
					report_mismatch($sformatf("best_index %h, want %h",
						best_index, due_entry.index));
				if (entry_valid !== due_entry.valid)
					report_mismatch($sformatf("entry_valid %b, want %b",
						entry_valid, due_entry.valid));
				if (last_entry !== due_entry.last)
					report_mismatch($sformatf("last_entry %b, want %b",
						last_entry, due_entry.last));
			end
			results_seen++;
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results still due",
				cycle_count, ranking_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_request(input logic [SCORE_BITS-1:0] s,
			input logic [INDEX_BITS-1:0] idx, input logic eov);
		score_req_t q;
		q.score = s;
		q.index = idx;
		q.eov   = eov;
		score_backlog = {score_backlog, q};
	endtask

	// Wait until every request is in and every due entry has come out,
	// then let the chain go quiet.
	task automatic settle();
		while (score_backlog.size() != 0 || start || ranking_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Only called while the block is idle; the model copy follows at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		if (which == REG_KEEP_COUNT)
			keep_cfg = value[KEEP_W-1:0];
		else if (which == REG_MIN_SCORE)
			floor_cfg = value[SCORE_BITS-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int                    kc;
		int                    vec_count;
		int                    vec_len;
		int                    v;
		int                    j;
		int                    near;
		int                    random_sent;
		bit                    leave_open;
		bit                    seq_index;
		logic [SCORE_BITS-1:0] s;
		logic [SCORE_BITS-1:0] prev_s;
		logic [INDEX_BITS-1:0] idx_base;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: keep one, no threshold; the extremes of both fields.
		gap_max = 0;
		settings_used++;
		queue_request(16'h0000, 16'h0000, 1'b0);
		queue_request(16'hFFFF, 16'hFFFF, 1'b1);
		settle();

		// Full store with the threshold at mid scale: below dropped, equal kept,
		// equal scores ranked by arrival.
		write_reg(REG_KEEP_COUNT, 16'hFFF0);
		write_reg(REG_MIN_SCORE, 16'h8000);
		settings_used++;
		gap_max = 3;
		queue_request(16'h7FFF, 16'h0001, 1'b0);
		queue_request(16'h8000, 16'h0002, 1'b0);
		queue_request(16'h9000, 16'h0003, 1'b0);
		queue_request(16'h9000, 16'h0004, 1'b0);
		queue_request(16'h8000, 16'h0005, 1'b1);
		settle();

		// Nothing passes the threshold: one invalid marker.
		queue_request(16'h0001, 16'h0007, 1'b1);
		settle();

		// Keep two: a score equal to the smallest held one, and a lower one, are refused.
		write_reg(REG_KEEP_COUNT, 16'h0002);
		write_reg(REG_MIN_SCORE, 16'h0000);
		settings_used++;
		queue_request(16'h5000, 16'h000A, 1'b0);
		queue_request(16'h6000, 16'h000B, 1'b0);
		queue_request(16'h5000, 16'h000C, 1'b0);
		queue_request(16'h4000, 16'h000D, 1'b0);
		queue_request(16'h7000, 16'h000E, 1'b1);
		settle();

		// keep_count of zero behaves as one; writes to unused indexes change nothing.
		write_reg(REG_KEEP_COUNT, 16'hFFE0);
		write_reg(REG_SPARE_A, 16'h5A5A);
		write_reg(REG_SPARE_B, 16'hA5A5);
		settings_used++;
		queue_request(16'h1234, 16'h0001, 1'b0);
		queue_request(16'h1235, 16'h0002, 1'b1);
		settle();

		// keep_count above the store depth saturates.
		write_reg(REG_KEEP_COUNT, 16'h001F);
		settings_used++;
		queue_request(16'h0100, 16'hBEEF, 1'b0);
		queue_request(16'h0200, 16'h1234, 1'b1);
		settle();

		// Lower keep_count while entries are held: the store is cut to its best.
		write_reg(REG_KEEP_COUNT, 16'h0004);
		settings_used++;
		queue_request(16'h1000, 16'h0001, 1'b0);
		queue_request(16'h3000, 16'h0002, 1'b0);
		queue_request(16'h2000, 16'h0003, 1'b0);
		settle();
		write_reg(REG_KEEP_COUNT, 16'h0002);
		settings_used++;
		queue_request(16'h0500, 16'h0004, 1'b1);
		settle();

		// Random phases: new settings, then a few vectors of random length,
		// sometimes left open so the next setting lands mid-vector.
		random_sent = 0;
		prev_s      = '0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0:       kc = 1;
				1:       kc = K_MAX;
				2:       kc = $urandom_range(K_MAX + 1, 31);
				3:       kc = 0;
				default: kc = $urandom_range(2, K_MAX - 1);
			endcase
			write_reg(REG_KEEP_COUNT,
				(CFG_DATA_W'($urandom) & ~CFG_DATA_W'(5'h1F)) | CFG_DATA_W'(kc));
			case ($urandom_range(0, 4))
				0:       write_reg(REG_MIN_SCORE, 16'h0000);
				1:       write_reg(REG_MIN_SCORE, 16'hFFFF);
				2:       write_reg(REG_MIN_SCORE, 16'($urandom));
				default: write_reg(REG_MIN_SCORE, 16'($urandom_range(0, 16'h3FFF)));
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
			settings_used++;

			// stretches with no idling, others with a random idle gap after each request
			gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 3;
			vec_count  = $urandom_range(1, 4);
			leave_open = ($urandom_range(0, 3) == 0);
			for (v = 0; v < vec_count; v++) begin
				vec_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(K_MAX + 1, 40)
					: $urandom_range(1, 12);
				seq_index = ($urandom_range(0, 3) != 0);
				idx_base  = 16'($urandom);
				for (j = 0; j < vec_len; j++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: s = 16'($urandom);
						4:          s = floor_cfg;
						5:          s = (floor_cfg == 0) ? 16'h0000 : floor_cfg - 16'h0001;
						6:          s = 16'hFFFF;
						7:          s = 16'h0000;
						8: begin
							near = int'(floor_cfg) + $urandom_range(0, 255);
							s    = (near > 16'hFFFF) ? 16'hFFFF : 16'(near);
						end
						default:    s = prev_s;
					endcase
					prev_s = s;
					queue_request(s, seq_index ? idx_base + 16'(j) : 16'($urandom),
						(j == vec_len - 1) && !(leave_open && v == vec_count - 1));
					random_sent++;
				end
			end
			settle();
		end

		settle();
		repeat (20) @(negedge clk);

		$display("Covered %0d score requests over %0d register settings",
			requests_taken, settings_used);
		$display("Checked %0d ranked results, %0d field mismatches",
			results_seen, mismatch_count);
		if (mismatch_count == 0 && ranking_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
